>>> hw/rtl/sorted_key_value_table_unit_assert.svh
// ----------------------------------------------------------------------------
// Sorted key/value table: assertion macros
// Shared property forms for the checker files of this block.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_VALUE_TABLE_UNIT_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent; sampled on
// clock, off while reset is high.
`define SKVT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SKVT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/skvt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key/value table: package
// Field widths, stream packing and operation codes for the table unit.
// ----------------------------------------------------------------------------
package skvt_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int FUNC_W  = 2;
   localparam int OUT_W   = 32;
   localparam int COUNT_W = 7;

   // request stream: tuser = func, tdata = key, value
   localparam int REQ_TUSER_W = FUNC_W;
   localparam int REQ_TDATA_W = KEY_W + VALUE_W;

   // response stream: tuser = ok, full_res; tdata = data_out, count, pad
   localparam int RSP_TUSER_W = 2;
   localparam int RSP_OK_BIT   = 0;
   localparam int RSP_FULL_BIT = 1;
   localparam int RSP_FIELD_W = OUT_W + COUNT_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD     = 2'd0,
      FUNC_REPLACE = 2'd1,
      FUNC_REMOVE  = 2'd2,
      FUNC_GET     = 2'd3
   } func_type;

endpackage

>>> hw/rtl/skvt_ram.sv
// ----------------------------------------------------------------------------
// Sorted key/value table: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module skvt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/sorted_key_value_table_unit.sv
// ----------------------------------------------------------------------------
// Sorted key/value table unit
// Ordered table of keys with data words, searched by binary search.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation per transfer: add if absent, add or replace,
//   remove or get, with a key and a data word. rsp_* returns one result per
//   request: ok, full_res, the data found by a get and the entry count.
//   Entries live in one RAM (key and data side by side) with a registered
//   read port, so each probe of the lower-bound search puts the address out
//   and then compares. A search over n entries takes at most ceil(log2(n+1))
//   probes. Insert and remove move every later entry by one slot, reading
//   each moved entry and then writing it back, and then write the new entry
//   or drop the count. req_tready is low from the request transfer until
//   the result enters the output register.
//   A finished result sits in the output register; the unit takes the next
//   request while the receiver stalls, and holds the following result back
//   until the register is free.
//   Reset empties the table at once (count to zero); RAM contents are left
//   as they are and are never read above the count, so no clearing pass.
// ----------------------------------------------------------------------------
module sorted_key_value_table_unit #(
   parameter int CAPACITY   = skvt_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = skvt_pkg::DATA_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [skvt_pkg::REQ_TDATA_W-1:0] req_tdata,  // key[31:0], value[63:32]
   input  logic [skvt_pkg::REQ_TUSER_W-1:0] req_tuser,  // func[1:0]
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [skvt_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // data_out[31:0], count[38:32], 0
   output logic [skvt_pkg::RSP_TUSER_W-1:0] rsp_tuser   // ok[0], full_res[1]
);
   import skvt_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int RW = KEY_W + DATA_WIDTH;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMPARE,
      ST_DECIDE,
      ST_SHUP_RD,
      ST_SHUP_WR,
      ST_SHDN_RD,
      ST_SHDN_WR,
      ST_FINISH
   } state_type;

   // sequencer state and registered outputs
   state_type             state_ff,     state_in;
   logic [CW-1:0]         count_ff,     count_in;
   logic [CW-1:0]         lo_ff,        lo_in;
   logic [CW-1:0]         hi_ff,        hi_in;
   logic [CW-1:0]         idx_ff,       idx_in;
   logic                  hit_ff,       hit_in;
   logic [DATA_WIDTH-1:0] hit_val_ff,   hit_val_in;
   func_type              func_ff,      func_in;
   logic [KEY_W-1:0]      key_ff,       key_in;
   logic [DATA_WIDTH-1:0] val_ff,       val_in;
   logic                  res_ok_ff,    res_ok_in;
   logic                  res_full_ff,  res_full_in;
   logic [OUT_W-1:0]      res_data_ff,  res_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff,    rsp_ok_in;
   logic                  rsp_full_ff,  rsp_full_in;
   logic [OUT_W-1:0]      rsp_data_ff,  rsp_data_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   // RAM port
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [RW-1:0] ram_wdata;
   logic          ram_re;
   logic [AW-1:0] ram_raddr;
   logic [RW-1:0] ram_rdata;

   logic                  req_fire;
   logic [CW-1:0]         mid;
   logic [CW-1:0]         idx_dec;
   logic [CW-1:0]         idx_inc;
   logic [KEY_W-1:0]      rd_key;
   logic [DATA_WIDTH-1:0] rd_val;
   logic [63:0]           val_wide;
   logic [63:0]           hit_wide;
   logic [31:0]           count_wide;

   skvt_ram #(
      .WIDTH (RW),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_dec = idx_ff - CW'(1);
   assign idx_inc = idx_ff + CW'(1);
   assign rd_key  = ram_rdata[RW-1 -: KEY_W];
   assign rd_val  = ram_rdata[DATA_WIDTH-1:0];

   // stored data is the request word fitted to DATA_WIDTH; results give its low 32 bits
   assign val_wide   = 64'(req_tdata[REQ_TDATA_W-1 -: VALUE_W]);
   assign hit_wide   = 64'(hit_val_ff);
   assign count_wide = 32'(count_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      hit_val_in   = hit_val_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      res_ok_in    = res_ok_ff;
      res_full_in  = res_full_ff;
      res_data_in  = res_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_count_in = rsp_count_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in  = func_type'(req_tuser[FUNC_W-1:0]);
               key_in   = req_tdata[KEY_W-1:0];
               val_in   = val_wide[DATA_WIDTH-1:0];
               lo_in    = '0;
               hi_in    = count_ff;
               hit_in   = 1'b0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // probe the middle of the open range, or stop once it is empty
            if (lo_ff < hi_ff) begin
               ram_re    = 1'b1;
               ram_raddr = mid[AW-1:0];
               state_in  = ST_COMPARE;
            end else begin
               state_in  = ST_DECIDE;
            end
         end
         ST_COMPARE: begin
            // the last probe that lowers hi sits at the final position
            if (rd_key < key_ff) begin
               lo_in = mid + CW'(1);
            end else begin
               hi_in      = mid;
               hit_in     = (rd_key == key_ff);
               hit_val_in = rd_val;
            end
            state_in = ST_SEARCH;
         end
         ST_DECIDE: begin
            res_ok_in   = 1'b0;
            res_full_in = 1'b0;
            res_data_in = '0;
            state_in    = ST_FINISH;
            case (func_ff)
               FUNC_ADD, FUNC_REPLACE: begin
                  if (hit_ff) begin
                     if (func_ff == FUNC_REPLACE) begin
                        ram_we    = 1'b1;
                        ram_waddr = lo_ff[AW-1:0];
                        ram_wdata = {key_ff, val_ff};
                        res_ok_in = 1'b1;
                     end
                  end else if (count_ff < CW'(CAPACITY)) begin
                     res_ok_in = (func_ff == FUNC_ADD);
                     idx_in    = count_ff;
                     state_in  = ST_SHUP_RD;
                  end else begin
                     res_full_in = 1'b1;
                  end
               end
               FUNC_REMOVE: begin
                  if (hit_ff) begin
                     res_ok_in = 1'b1;
                     idx_in    = lo_ff;
                     state_in  = ST_SHDN_RD;
                  end
               end
               FUNC_GET: begin
                  if (hit_ff) begin
                     res_ok_in   = 1'b1;
                     res_data_in = hit_wide[OUT_W-1:0];
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_SHUP_RD: begin
            // move entries up from the top, then drop the new entry into its slot
            if (idx_ff > lo_ff) begin
               ram_re    = 1'b1;
               ram_raddr = idx_dec[AW-1:0];
               state_in  = ST_SHUP_WR;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = lo_ff[AW-1:0];
               ram_wdata = {key_ff, val_ff};
               count_in  = count_ff + CW'(1);
               state_in  = ST_FINISH;
            end
         end
         ST_SHUP_WR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff[AW-1:0];
            ram_wdata = ram_rdata;
            idx_in    = idx_dec;
            state_in  = ST_SHUP_RD;
         end
         ST_SHDN_RD: begin
            // pull each later entry down over the removed one
            if (idx_inc < count_ff) begin
               ram_re    = 1'b1;
               ram_raddr = idx_inc[AW-1:0];
               state_in  = ST_SHDN_WR;
            end else begin
               count_in  = count_ff - CW'(1);
               state_in  = ST_FINISH;
            end
         end
         ST_SHDN_WR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff[AW-1:0];
            ram_wdata = ram_rdata;
            idx_in    = idx_inc;
            state_in  = ST_SHDN_RD;
         end
         ST_FINISH: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_full_in  = res_full_ff;
               rsp_data_in  = res_data_ff;
               rsp_count_in = count_wide[COUNT_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         idx_ff       <= idx_in;
         hit_ff       <= hit_in;
         hit_val_ff   <= hit_val_in;
         func_ff      <= func_in;
         key_ff       <= key_in;
         val_ff       <= val_in;
         res_ok_ff    <= res_ok_in;
         res_full_ff  <= res_full_in;
         res_data_ff  <= res_data_in;
         rsp_ok_ff    <= rsp_ok_in;
         rsp_full_ff  <= rsp_full_in;
         rsp_data_ff  <= rsp_data_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_count_ff, rsp_data_ff};
   assign rsp_tuser  = {rsp_full_ff, rsp_ok_ff};

endmodule

>>> hw/rtl/skvt_checker.sv
// ----------------------------------------------------------------------------
// Sorted key/value table: port checker
// Watches the unit's stream ports and flags results that break its rules.
// ----------------------------------------------------------------------------
`include "sorted_key_value_table_unit_assert.svh"

module skvt_checker #(
   parameter int CAPACITY = skvt_pkg::CAPACITY_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [skvt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [skvt_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import skvt_pkg::*;

   logic [COUNT_W-1:0]                     rsp_count;
   logic                                   rsp_ok;
   logic                                   rsp_full;
   logic [RSP_TDATA_W+RSP_TUSER_W-1:0]     rsp_word;
   logic                                   rsp_stall;
   logic                                   req_fire;
   logic                                   rsp_refused;
   logic                                   at_cap;
   logic                                   within_cap;

   assign rsp_count   = rsp_tdata[OUT_W +: COUNT_W];
   assign rsp_ok      = rsp_tuser[RSP_OK_BIT];
   assign rsp_full    = rsp_tuser[RSP_FULL_BIT];
   assign rsp_word    = {rsp_tuser, rsp_tdata};
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign req_fire    = req_tvalid && req_tready;
   assign rsp_refused = rsp_tvalid && rsp_full;
   assign at_cap      = (CAPACITY > 127) || (rsp_count == COUNT_W'(CAPACITY));
   assign within_cap  = (CAPACITY > 127) || (rsp_count <= COUNT_W'(CAPACITY));

   // a stalled result holds
   `SKVT_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_word), "held result changed")

   // one request at a time: the unit is busy right after a transfer
   `SKVT_ASSERT_NEXT(a_req_busy, req_fire, !req_tready, "request taken while busy")

   // a refused insert never reports success
   `SKVT_ASSERT_SAME(a_full_not_ok, rsp_refused, !rsp_ok, "full result also reports ok")

   // refusal only happens at capacity
   `SKVT_ASSERT_SAME(a_full_count, rsp_refused, at_cap, "full result below capacity")

   // count never goes past capacity
   `SKVT_ASSERT_SAME(a_count_cap, rsp_tvalid, within_cap, "count above capacity")

endmodule

bind sorted_key_value_table_unit skvt_checker #(
   .CAPACITY (CAPACITY)
) u_skvt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key/value table unit: testbench
// Streams add, replace, remove and get requests into the table, predicts
// each result from a local sorted table and checks every response field.
// ----------------------------------------------------------------------------
module testbench;
   import skvt_pkg::*;

   localparam int TABLE_DEPTH   = CAPACITY_DEF;
   localparam int RANDOM_ITEMS  = 500;
   localparam int FILL_POOL     = TABLE_DEPTH + 16;
   localparam int MIX_POOL      = 12;
   localparam int CYCLE_LIMIT   = 800000;
   localparam int DRAIN_CYCLES  = 300;
   localparam int LONG_STALL    = 300;

   typedef struct {
      func_type             func;
      logic [KEY_W-1:0]     key;
      logic [VALUE_W-1:0]   value;
   } table_op_type;

   typedef struct {
      logic                 ok;
      logic                 full;
      logic [OUT_W-1:0]     data;
      logic [COUNT_W-1:0]   count;
   } table_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;   // key[31:0], value[63:32]
   logic [REQ_TUSER_W-1:0]  req_tuser = '0;   // func[1:0]
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;        // data_out[31:0], count[38:32], pad
   logic [RSP_TUSER_W-1:0]  rsp_tuser;        // ok[0], full_res[1]

   // Local copy of the table, kept sorted ascending by key.
   logic [KEY_W-1:0]        table_keys [TABLE_DEPTH];
   logic [VALUE_W-1:0]      table_values [TABLE_DEPTH];
   int                      table_count = 0;

   table_op_type            pending_ops [$];
   table_result_type        expected_results [$];

   int                      ops_queued = 0;
   int                      ops_accepted = 0;
   int                      results_seen = 0;
   int                      error_count = 0;
   int                      cycle_count = 0;
   int                      stall_left = 0;
   int                      next_stall_at = 40;

   sorted_key_value_table_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Apply one operation to the local table and return the result it yields.
   function automatic table_result_type apply_table_op(table_op_type op);
      table_result_type res;
      int               slot;
      int               idx;
      bit               present;
      res.ok    = 1'b0;
      res.full  = 1'b0;
      res.data  = '0;
      slot = 0;
      // lower bound: first slot whose key is not below the search key
      while (slot < table_count && table_keys[slot] < op.key) slot++;
      present = (slot < table_count) && (table_keys[slot] == op.key);
      case (op.func)
         FUNC_ADD, FUNC_REPLACE: begin
            if (present) begin
               if (op.func == FUNC_REPLACE) begin
                  table_values[slot] = op.value;
                  res.ok = 1'b1;
               end
            end else if (table_count < TABLE_DEPTH) begin
               // open a gap at the insert point
               for (idx = table_count; idx > slot; idx--) begin
                  table_keys[idx]   = table_keys[idx-1];
                  table_values[idx] = table_values[idx-1];
               end
               table_keys[slot]   = op.key;
               table_values[slot] = op.value;
               table_count++;
               res.ok = (op.func == FUNC_ADD);
            end else begin
               res.full = 1'b1;
            end
         end
         FUNC_REMOVE: begin
            if (present) begin
               for (idx = slot; idx + 1 < table_count; idx++) begin
                  table_keys[idx]   = table_keys[idx+1];
                  table_values[idx] = table_values[idx+1];
               end
               table_count--;
               res.ok = 1'b1;
            end
         end
         default: begin
            if (present) begin
               res.data = table_values[slot];
               res.ok   = 1'b1;
            end
         end
      endcase
      res.count = COUNT_W'(table_count);
      return res;
   endfunction

   function automatic logic [KEY_W-1:0] pick_key(logic [KEY_W-1:0] prev);
      int roll;
      roll = $urandom_range(99);
      if (roll < 3) return '0;
      if (roll < 6) return '1;
      // neighbors of the previous key stress the ordering
      if (roll < 16) return prev + 1'b1;
      return $urandom;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) return '0;
      if (roll < 10) return '1;
      return $urandom;
   endfunction

   task automatic push_op(func_type func, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
      table_op_type op;
      op.func  = func;
      op.key   = key;
      op.value = value;
      pending_ops.push_back(op);
      ops_queued++;
   endtask

   task automatic check_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   // Request driver: keep a stalled transfer on the bus, otherwise offer the
   // next pending operation unless this cycle idles.
   always @(posedge clock) begin
      bit idle_now;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(apply_table_op(pending_ops.pop_front()));
            ops_accepted++;
         end
         if (!(req_tvalid && !req_tready)) begin
            // no idling at all through a stretch of the run
            idle_now = !(ops_accepted >= 200 && ops_accepted < 300)
                       && ($urandom_range(99) < 14);
            if (pending_ops.size() > 0 && !idle_now) begin
               req_tvalid <= 1'b1;
               req_tuser  <= pending_ops[0].func;
               req_tdata  <= {pending_ops[0].value, pending_ops[0].key};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each transfer against the oldest expectation,
   // then pick the ready level for the next cycle.
   always @(posedge clock) begin
      table_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $error("response transfer with no request outstanding");
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("ok", OUT_W'(want.ok), OUT_W'(rsp_tuser[RSP_OK_BIT]));
               check_field("full_res", OUT_W'(want.full), OUT_W'(rsp_tuser[RSP_FULL_BIT]));
               check_field("data_out", want.data, rsp_tdata[OUT_W-1:0]);
               check_field("count", OUT_W'(want.count), OUT_W'(rsp_tdata[OUT_W +: COUNT_W]));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (results_seen >= next_stall_at) begin
            // hold off long enough for the unit to back up into its input
            next_stall_at += 410;
            stall_left = LONG_STALL;
            rsp_tready <= 1'b0;
         end else if (results_seen >= 200 && results_seen < 300) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 14);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      logic [KEY_W-1:0] key_pool [FILL_POOL];
      logic [KEY_W-1:0] prev_key;
      int               start;
      int               idx;
      int               roll;
      int               round_no;

      // Directed: empty table, key and data extremes, duplicates, replace
      // of present and absent keys, misses on remove and get, then back to
      // empty.
      push_op(FUNC_GET,     32'h0000_0000, 32'h0000_0000);
      push_op(FUNC_REMOVE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_op(FUNC_ADD,     32'h0000_0000, 32'hFFFF_FFFF);
      push_op(FUNC_ADD,     32'hFFFF_FFFF, 32'h0000_0000);
      push_op(FUNC_ADD,     32'h0000_0000, 32'h1234_5678);
      push_op(FUNC_REPLACE, 32'h0000_0000, 32'hA5A5_A5A5);
      push_op(FUNC_REPLACE, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
      push_op(FUNC_ADD,     32'h8000_0000, 32'h8000_0001);
      push_op(FUNC_GET,     32'h0000_0000, 32'hFFFF_FFFF);
      push_op(FUNC_GET,     32'hFFFF_FFFF, 32'h0000_0000);
      push_op(FUNC_GET,     32'h7FFF_FFFF, 32'h0000_0000);
      push_op(FUNC_GET,     32'h8000_0000, 32'h0000_0000);
      push_op(FUNC_GET,     32'h0000_0001, 32'h0000_0000);
      push_op(FUNC_REMOVE,  32'h7FFF_FFFF, 32'h0000_0000);
      push_op(FUNC_REMOVE,  32'h7FFF_FFFF, 32'h0000_0000);
      push_op(FUNC_GET,     32'h7FFF_FFFF, 32'h0000_0000);
      push_op(FUNC_REMOVE,  32'h0000_0000, 32'h0000_0000);
      push_op(FUNC_REMOVE,  32'hFFFF_FFFF, 32'h0000_0000);
      push_op(FUNC_REMOVE,  32'h8000_0000, 32'h0000_0000);
      push_op(FUNC_GET,     32'h8000_0000, 32'h0000_0000);

      // pause the sender until every directed result is back
      while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge clock);

      ops_queued = 0;
      round_no   = 0;
      prev_key   = '0;
      while (ops_queued < RANDOM_ITEMS) begin
         if (round_no == 0 || $urandom_range(2) == 0) begin
            // Fill past capacity, work on the full table, then drain it.
            for (idx = 0; idx < FILL_POOL; idx++) begin
               key_pool[idx] = pick_key(prev_key);
               prev_key = key_pool[idx];
            end
            for (idx = 0; idx < FILL_POOL; idx++)
               push_op(($urandom_range(3) == 0) ? FUNC_REPLACE : FUNC_ADD,
                       key_pool[idx], pick_value());
            repeat (16) begin
               roll = $urandom_range(3);
               if (roll == 0) push_op(FUNC_ADD, $urandom, pick_value());
               else if (roll == 1) push_op(FUNC_GET, key_pool[$urandom_range(FILL_POOL-1)], '0);
               else push_op(FUNC_REPLACE, key_pool[$urandom_range(FILL_POOL-1)], pick_value());
            end
            // stride 7 walks the whole pool in a scrambled order
            start = $urandom_range(FILL_POOL-1);
            for (idx = 0; idx < FILL_POOL; idx++) begin
               push_op(FUNC_REMOVE, key_pool[(start + idx*7) % FILL_POOL], pick_value());
               if ($urandom_range(9) == 0)
                  push_op(FUNC_GET, key_pool[$urandom_range(FILL_POOL-1)], pick_value());
            end
         end else begin
            // Mixed traffic on a small key set, with some noise keys.
            for (idx = 0; idx < MIX_POOL; idx++) begin
               key_pool[idx] = pick_key(prev_key);
               prev_key = key_pool[idx];
            end
            repeat (80) begin
               if ($urandom_range(9) == 0)
                  push_op(func_type'($urandom_range(3)), $urandom, $urandom);
               else
                  push_op(func_type'($urandom_range(3)), key_pool[$urandom_range(MIX_POOL-1)],
                          pick_value());
            end
         end
         round_no++;
         if ($urandom_range(2) == 0)
            while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge clock);
      end

      while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/skvt_pkg.sv
hw/rtl/skvt_ram.sv
hw/rtl/sorted_key_value_table_unit.sv
hw/rtl/skvt_checker.sv
test/testbench.sv
